// ===== rtl/bta_pkg.sv =====
package bta_pkg;

    typedef struct packed {
        logic        req_type;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] block_addr;
        logic [1:0]  status;
    } t_rsp;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FREED = 2'd1;
    localparam logic [1:0] ST_REJ   = 2'd2;
    localparam logic [1:0] ST_OOM   = 2'd3;

    // tag word address selects
    localparam logic [2:0] A_PM4  = 3'd0;  // p - 4        header
    localparam logic [2:0] A_PM8  = 3'd1;  // p - 8        previous footer
    localparam logic [2:0] A_PSM4 = 3'd2;  // p + sz - 4   next header
    localparam logic [2:0] A_PSM8 = 3'd3;  // p + sz - 8   footer
    localparam logic [2:0] A_PAM4 = 3'd4;  // p + asize - 4
    localparam logic [2:0] A_PAM8 = 3'd5;  // p + asize - 8
    localparam logic [2:0] A_INIT = 3'd6;

    // tag word data selects
    localparam logic [2:0] D_FREE = 3'd0;  // sz
    localparam logic [2:0] D_SZA  = 3'd1;  // sz | 1
    localparam logic [2:0] D_ASA  = 3'd2;  // asize | 1
    localparam logic [2:0] D_REM  = 3'd3;  // sz - asize
    localparam logic [2:0] D_ONE  = 3'd4;  // epilogue
    localparam logic [2:0] D_INIT = 3'd5;

    // datapath register operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_START = 4'd1;
    localparam logic [3:0] OP_SIZE  = 4'd2;
    localparam logic [3:0] OP_STEP  = 4'd3;
    localparam logic [3:0] OP_PREV  = 4'd4;
    localparam logic [3:0] OP_NEXT  = 4'd5;
    localparam logic [3:0] OP_MERGE = 4'd6;
    localparam logic [3:0] OP_NEED  = 4'd7;
    localparam logic [3:0] OP_GROW  = 4'd8;
    localparam logic [3:0] OP_BRK   = 4'd9;

    localparam int INIT_LAST = 4;

    typedef struct packed {
        logic       mem_rd;
        logic       mem_wr;
        logic [2:0] asel;
        logic [2:0] dsel;
        logic [2:0] init_idx;
        logic [3:0] op;
        logic       ld_out;
        logic [1:0] out_st;
    } t_cmd;

    typedef struct packed {
        logic req_type;
        logic req_zero;
        logic p_end;
        logic sz_small;
        logic rd_alloc;
        logic p_eq_fa;
        logic p_gt_fa;
        logic fits;
        logic oom;
        logic split;
        logic out_block;
    } t_sts;

endpackage

// ===== rtl/boundary_tag_heap_allocator.sv =====
// Boundary-tag heap allocator, implicit free list, first fit.
// Request channel: i_in_valid / o_in_stall carry one t_req transaction
// (allocate or free). Response channel: o_out_valid / i_out_stall return
// one t_rsp transaction per request (block address and status).
// Config: i_cfg_we writes extend_chunk; write only while the block is idle.
// Sequence: accept, a dispatch step, then the walk over block headers
// (tag read, then check, per block visited). A free that hits then
// rewrites its tags and coalesces; an allocate that fits writes its tags
// with or without a split, after growing the heap break when it has to.
// The response register is loaded last. The single-port
// tag memory bounds the rate; one request is in work at a time.
// Reset: an init sequence writes prologue, first free block and epilogue
// tags; requests stall until it is done. Other tag words are never read.
// Stall: the finished response sits in an output register; the next
// request is accepted meanwhile, and a later response waits until the
// register drains.
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bta_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bta_pkg::t_rsp o_out_data,
    input  logic          i_cfg_we,
    input  logic [16:0]   i_cfg_data
);
    import bta_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: walk, tag rewrite, coalesce, grow, split
    bta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // tag memory, address/size registers, response register
    bta_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/bta_dp.sv =====
module bta_dp #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bta_pkg::t_cmd i_cmd,
    output bta_pkg::t_sts o_sts,
    input  bta_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [16:0]   i_cfg_data,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output bta_pkg::t_rsp o_out_data
);
    import bta_pkg::*;

    localparam int NWORDS = HEAP_BYTES / 4;
    localparam int IW     = $clog2(NWORDS);
    localparam int AW     = $clog2(HEAP_BYTES) + 1;
    localparam int SW     = (AW > 18) ? AW : 18;
    localparam int ROOM0  = (HEAP_BYTES - 16) / 8 * 8;
    localparam int FIRST  = (ROOM0 < 4096) ? ROOM0 : 4096;

    localparam logic [SW-1:0] HEAP  = SW'(HEAP_BYTES);
    localparam logic [SW-1:0] FBLK  = SW'(FIRST);

    logic [31:0]   mem [NWORDS];
    logic [31:0]   r_mem;
    logic          r_rd_ok;

    logic [SW-1:0] r_p, r_sz, r_asize, r_tail, r_brk, r_ext, r_need, r_psz, r_nsz;
    logic          r_pa, r_na, r_type;
    logic [15:0]   r_req, r_fa;
    logic [16:0]   r_chunk;
    logic          r_ov;
    t_rsp          r_out;

    logic [SW-1:0] addr, init_addr, sz_rd, need_c, rnd, ext_max, room, ext_cl, rem;
    logic [31:0]   wdata, init_data, rdata;
    logic [IW-1:0] idx;
    logic          in_range;
    logic [13:0]   units;

    always_comb begin
        case (i_cmd.init_idx)
            3'd0:    begin init_addr = SW'(4);         init_data = 32'd9; end
            3'd1:    begin init_addr = SW'(8);         init_data = 32'd9; end
            3'd2:    begin init_addr = SW'(12);        init_data = 32'(FBLK); end
            3'd3:    begin init_addr = FBLK + SW'(8);  init_data = 32'(FBLK); end
            3'd4:    begin init_addr = FBLK + SW'(12); init_data = 32'd1; end
            default: begin init_addr = '0;             init_data = '0; end
        endcase
    end

    always_comb begin
        case (i_cmd.asel)
            A_PM4:   addr = r_p - SW'(4);
            A_PM8:   addr = r_p - SW'(8);
            A_PSM4:  addr = r_p + r_sz - SW'(4);
            A_PSM8:  addr = r_p + r_sz - SW'(8);
            A_PAM4:  addr = r_p + r_asize - SW'(4);
            A_PAM8:  addr = r_p + r_asize - SW'(8);
            A_INIT:  addr = init_addr;
            default: addr = '0;
        endcase
    end

    assign rem = r_sz - r_asize;

    always_comb begin
        case (i_cmd.dsel)
            D_FREE:  wdata = 32'(r_sz);
            D_SZA:   wdata = 32'(r_sz) | 32'd1;
            D_ASA:   wdata = 32'(r_asize) | 32'd1;
            D_REM:   wdata = 32'(rem);
            D_ONE:   wdata = 32'd1;
            D_INIT:  wdata = init_data;
            default: wdata = '0;
        endcase
    end

    assign idx      = addr[IW+1:2];
    assign in_range = addr[SW-1:2] < (SW-2)'(NWORDS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && in_range) begin
            mem[idx] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_mem   <= mem[idx];
            r_rd_ok <= in_range;
        end
    end

    assign rdata = r_rd_ok ? r_mem : 32'd0;
    assign sz_rd = {rdata[SW-1:3], 3'b000};

    assign need_c  = r_asize - r_tail;
    assign rnd     = SW'(({1'b0, r_chunk} + 18'd7) & ~18'd7);
    assign ext_max = (rnd < need_c) ? need_c : rnd;
    assign room    = (r_brk <= HEAP) ? ((HEAP - r_brk) & ~SW'(7)) : '0;
    assign ext_cl  = (r_ext > room) ? room : r_ext;
    assign units   = 14'((i_req.req_size - 16'd1) >> 3) + 14'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk   <= FBLK + SW'(16);
            r_chunk <= 17'd4096;
        end else begin
            if (i_cfg_we) begin
                r_chunk <= i_cfg_data;
            end
            if (i_cmd.op == OP_BRK) begin
                r_brk <= r_p + r_sz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_type  <= i_req.req_type;
                r_req   <= i_req.req_size;
                r_fa    <= i_req.free_addr;
                r_p     <= SW'(16);
                r_tail  <= '0;
                r_asize <= SW'({units, 3'b000});
            end
            OP_SIZE: r_sz <= sz_rd;
            OP_STEP: begin
                r_sz   <= sz_rd;
                r_p    <= r_p + sz_rd;
                r_tail <= rdata[0] ? '0 : sz_rd;
            end
            OP_PREV: begin
                r_pa  <= rdata[0];
                r_psz <= sz_rd;
            end
            OP_NEXT: begin
                r_na  <= rdata[0];
                r_nsz <= sz_rd;
            end
            OP_MERGE: begin
                r_p  <= r_pa ? r_p : r_p - r_psz;
                r_sz <= r_sz + (r_pa ? '0 : r_psz) + (r_na ? '0 : r_nsz);
            end
            OP_NEED: begin
                r_need <= need_c;
                r_ext  <= ext_max;
            end
            OP_GROW: begin
                r_p  <= r_brk;
                r_sz <= ext_cl;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out.status     <= i_cmd.out_st;
            r_out.block_addr <= (i_cmd.out_st == ST_ALLOC) ? r_p[15:0] : 16'd0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign o_sts.req_type  = r_type;
    assign o_sts.req_zero  = (r_req == 16'd0);
    assign o_sts.p_end     = (r_p >= r_brk);
    assign o_sts.sz_small  = (sz_rd < SW'(8));
    assign o_sts.rd_alloc  = rdata[0];
    assign o_sts.p_eq_fa   = (r_p == SW'(r_fa));
    assign o_sts.p_gt_fa   = (r_p > SW'(r_fa));
    assign o_sts.fits      = (sz_rd >= r_asize);
    assign o_sts.oom       = (ext_cl < r_need);
    assign o_sts.split     = (rem >= SW'(16));
    assign o_sts.out_block = r_ov && i_out_stall;

endmodule

// ===== rtl/bta_ctrl.sv =====
module bta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bta_pkg::t_sts i_sts,
    output bta_pkg::t_cmd o_cmd
);
    import bta_pkg::*;

    localparam logic [4:0] S_INIT = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DISP = 5'd2;
    localparam logic [4:0] S_FHDR = 5'd3;
    localparam logic [4:0] S_FCHK = 5'd4;
    localparam logic [4:0] S_FT1  = 5'd5;
    localparam logic [4:0] S_FT2  = 5'd6;
    localparam logic [4:0] S_CR1  = 5'd7;
    localparam logic [4:0] S_CR2  = 5'd8;
    localparam logic [4:0] S_CR3  = 5'd9;
    localparam logic [4:0] S_CMB  = 5'd10;
    localparam logic [4:0] S_CW1  = 5'd11;
    localparam logic [4:0] S_CW2  = 5'd12;
    localparam logic [4:0] S_AHDR = 5'd13;
    localparam logic [4:0] S_ACHK = 5'd14;
    localparam logic [4:0] S_G1   = 5'd15;
    localparam logic [4:0] S_G2   = 5'd16;
    localparam logic [4:0] S_GW1  = 5'd17;
    localparam logic [4:0] S_GW2  = 5'd18;
    localparam logic [4:0] S_GW3  = 5'd19;
    localparam logic [4:0] S_OC1  = 5'd20;
    localparam logic [4:0] S_OC2  = 5'd21;
    localparam logic [4:0] S_OC3  = 5'd22;
    localparam logic [4:0] S_OC4  = 5'd23;
    localparam logic [4:0] S_FIN  = 5'd24;

    logic [4:0] r_state, n_state;
    logic [2:0] r_icnt, n_icnt;
    logic [1:0] r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_icnt  <= '0;
            r_res   <= ST_REJ;
        end else begin
            r_state <= n_state;
            r_icnt  <= n_icnt;
            r_res   <= n_res;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_icnt  = r_icnt;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.out_st = r_res;
        case (r_state)
            S_INIT: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.asel     = A_INIT;
                o_cmd.dsel     = D_INIT;
                o_cmd.init_idx = r_icnt;
                if (r_icnt == 3'(INIT_LAST)) begin
                    n_state = S_IDLE;
                end else begin
                    n_icnt = r_icnt + 3'd1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_START;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.req_type == REQ_FREE) begin
                    n_state = S_FHDR;
                end else if (i_sts.req_zero) begin
                    n_res   = ST_REJ;
                    n_state = S_FIN;
                end else begin
                    n_state = S_AHDR;
                end
            end
            S_FHDR: begin
                if (i_sts.p_end) begin
                    n_res   = ST_REJ;
                    n_state = S_FIN;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.asel   = A_PM4;
                    n_state      = S_FCHK;
                end
            end
            S_FCHK: begin
                if (i_sts.sz_small || (i_sts.p_eq_fa && !i_sts.rd_alloc) ||
                    (!i_sts.p_eq_fa && i_sts.p_gt_fa)) begin
                    n_res   = ST_REJ;
                    n_state = S_FIN;
                end else if (i_sts.p_eq_fa) begin
                    o_cmd.op = OP_SIZE;
                    n_state  = S_FT1;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state  = S_FHDR;
                end
            end
            S_FT1: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PM4;
                o_cmd.dsel   = D_FREE;
                n_state      = S_FT2;
            end
            S_FT2: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PSM8;
                o_cmd.dsel   = D_FREE;
                n_state      = S_CR1;
            end
            S_CR1: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = A_PM8;
                n_state      = S_CR2;
            end
            S_CR2: begin
                o_cmd.op     = OP_PREV;
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = A_PSM4;
                n_state      = S_CR3;
            end
            S_CR3: begin
                o_cmd.op = OP_NEXT;
                n_state  = S_CMB;
            end
            S_CMB: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_CW1;
            end
            S_CW1: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PM4;
                o_cmd.dsel   = D_FREE;
                n_state      = S_CW2;
            end
            S_CW2: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PSM8;
                o_cmd.dsel   = D_FREE;
                if (i_sts.req_type == REQ_FREE) begin
                    n_res   = ST_FREED;
                    n_state = S_FIN;
                end else begin
                    n_state = S_OC1;
                end
            end
            S_AHDR: begin
                if (i_sts.p_end) begin
                    n_state = S_G1;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.asel   = A_PM4;
                    n_state      = S_ACHK;
                end
            end
            S_ACHK: begin
                if (i_sts.sz_small) begin
                    n_state = S_G1;
                end else if (!i_sts.rd_alloc && i_sts.fits) begin
                    o_cmd.op = OP_SIZE;
                    n_state  = S_OC1;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state  = S_AHDR;
                end
            end
            S_G1: begin
                o_cmd.op = OP_NEED;
                n_state  = S_G2;
            end
            S_G2: begin
                if (i_sts.oom) begin
                    n_res   = ST_OOM;
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_GROW;
                    n_state  = S_GW1;
                end
            end
            S_GW1: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PM4;
                o_cmd.dsel   = D_FREE;
                n_state      = S_GW2;
            end
            S_GW2: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PSM8;
                o_cmd.dsel   = D_FREE;
                n_state      = S_GW3;
            end
            S_GW3: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PSM4;
                o_cmd.dsel   = D_ONE;
                o_cmd.op     = OP_BRK;
                n_state      = S_CR1;
            end
            S_OC1: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PM4;
                o_cmd.dsel   = i_sts.split ? D_ASA : D_SZA;
                n_state      = S_OC2;
            end
            S_OC2: begin
                o_cmd.mem_wr = 1'b1;
                if (i_sts.split) begin
                    o_cmd.asel = A_PAM8;
                    o_cmd.dsel = D_ASA;
                    n_state    = S_OC3;
                end else begin
                    o_cmd.asel = A_PSM8;
                    o_cmd.dsel = D_SZA;
                    n_res      = ST_ALLOC;
                    n_state    = S_FIN;
                end
            end
            S_OC3: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PAM4;
                o_cmd.dsel   = D_REM;
                n_state      = S_OC4;
            end
            S_OC4: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = A_PSM8;
                o_cmd.dsel   = D_REM;
                n_res        = ST_ALLOC;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_block) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/bta_chk.sv =====
module bta_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input bta_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bta_pkg::t_rsp o_out_data
);
    import bta_pkg::*;

    // one request in work at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response changed");

    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == ST_ALLOC) ?
            (o_out_data.block_addr[2:0] == 3'd0) : (o_out_data.block_addr == 16'd0)))
        else $error("response address inconsistent with status");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_stall))
        else $error("not idle after reset");

endmodule

bind boundary_tag_heap_allocator bta_chk u_bta_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
